[sv/chip8_instruction_core_macros.svh]
// assertion helpers used by the checker file
`ifndef CHIP8_INSTRUCTION_CORE_MACROS_SVH
`define CHIP8_INSTRUCTION_CORE_MACROS_SVH

// same-cycle implication
`define C8IC_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("c8ic assertion failed");

// next-cycle implication
`define C8IC_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("c8ic assertion failed");

`endif

[sv/c8ic_pkg.sv]
`timescale 1ns / 1ps

package c8ic_pkg;

  localparam int MemBytesDef     = 4096;
  localparam int StackDepthDef   = 16;
  localparam int ProgramStartDef = 512;
  localparam int ScreenWidth     = 64;
  localparam int ScreenHeight    = 32;
  localparam int FontBytes       = 80;

  localparam logic [7:0] FontRom [FontBytes] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] mem_addr;
    logic [7:0]  mem_data;
    logic [15:0] keys;
    logic [7:0]  random_byte;
    logic [5:0]  display_word;
  } in_req_t;

  typedef struct packed {
    logic [11:0] pc;
    logic [15:0] opcode;
    logic [1:0]  status;
    logic        collision;
    logic        sound_on;
    logic [31:0] row_data;
  } out_rsp_t;

  typedef enum logic [1:0] {
    FUNC_LOAD, FUNC_EXEC, FUNC_TICK, FUNC_DISP
  } func_e;

  typedef enum logic [1:0] {
    ST_OK, ST_UNKNOWN, ST_OVERFLOW, ST_UNDERFLOW
  } status_e;

  typedef enum logic [2:0] {
    KIND_SIMPLE, KIND_FLAG, KIND_SPRITE, KIND_BCD, KIND_STORE, KIND_LOAD
  } op_kind_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_FETCH_LO, S_DECODE, S_READ_VX, S_READ_VY,
    S_EXEC, S_SPR_RD, S_SPR_WR, S_BCD, S_STORE, S_LOAD_RD, S_LOAD_WR, S_FLAG,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LATCH, CMD_DISPATCH, CMD_FETCH_LO, CMD_DECODE,
    CMD_READ_VX, CMD_READ_VY, CMD_EXEC, CMD_SPR_RD, CMD_SPR_WR, CMD_BCD,
    CMD_STORE, CMD_LOAD_RD, CMD_LOAD_WR, CMD_FLAG, CMD_EMIT
  } dp_cmd_e;

  typedef struct packed {
    logic     clr_last;
    func_e    func;
    op_kind_e kind;
    logic     loop_last;
  } dp_status_t;

endpackage

[sv/c8ic_ram.sv]
`timescale 1ns / 1ps

module c8ic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/c8ic_ctrl.sv]
`timescale 1ns / 1ps

module c8ic_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output c8ic_pkg::dp_cmd_e    cmd_o,
  input  c8ic_pkg::dp_status_t sts_i
);

  c8ic_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c8ic_pkg::S_CLEAR:    if (sts_i.clr_last) state_d = c8ic_pkg::S_IDLE;
      c8ic_pkg::S_IDLE:     if (in_valid_i) state_d = c8ic_pkg::S_DISPATCH;
      c8ic_pkg::S_DISPATCH: begin
        state_d = (sts_i.func == c8ic_pkg::FUNC_EXEC) ? c8ic_pkg::S_FETCH_LO
                                                      : c8ic_pkg::S_DONE;
      end
      c8ic_pkg::S_FETCH_LO: state_d = c8ic_pkg::S_DECODE;
      c8ic_pkg::S_DECODE:   state_d = c8ic_pkg::S_READ_VX;
      c8ic_pkg::S_READ_VX:  state_d = c8ic_pkg::S_READ_VY;
      c8ic_pkg::S_READ_VY:  state_d = c8ic_pkg::S_EXEC;
      c8ic_pkg::S_EXEC: begin
        unique case (sts_i.kind)
          c8ic_pkg::KIND_FLAG:   state_d = c8ic_pkg::S_FLAG;
          c8ic_pkg::KIND_SPRITE: state_d = c8ic_pkg::S_SPR_RD;
          c8ic_pkg::KIND_BCD:    state_d = c8ic_pkg::S_BCD;
          c8ic_pkg::KIND_STORE:  state_d = c8ic_pkg::S_STORE;
          c8ic_pkg::KIND_LOAD:   state_d = c8ic_pkg::S_LOAD_RD;
          default:               state_d = c8ic_pkg::S_DONE;
        endcase
      end
      c8ic_pkg::S_SPR_RD:  state_d = c8ic_pkg::S_SPR_WR;
      c8ic_pkg::S_SPR_WR:  begin
        state_d = sts_i.loop_last ? c8ic_pkg::S_FLAG : c8ic_pkg::S_SPR_RD;
      end
      c8ic_pkg::S_BCD:     if (sts_i.loop_last) state_d = c8ic_pkg::S_DONE;
      c8ic_pkg::S_STORE:   if (sts_i.loop_last) state_d = c8ic_pkg::S_DONE;
      c8ic_pkg::S_LOAD_RD: state_d = c8ic_pkg::S_LOAD_WR;
      c8ic_pkg::S_LOAD_WR: begin
        state_d = sts_i.loop_last ? c8ic_pkg::S_DONE : c8ic_pkg::S_LOAD_RD;
      end
      c8ic_pkg::S_FLAG:    state_d = c8ic_pkg::S_DONE;
      c8ic_pkg::S_DONE:    if (out_free) state_d = c8ic_pkg::S_IDLE;
      default:             state_d = c8ic_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = c8ic_pkg::CMD_NONE;
    unique case (state_q)
      c8ic_pkg::S_CLEAR:    cmd_o = c8ic_pkg::CMD_CLEAR;
      c8ic_pkg::S_IDLE:     if (in_valid_i) cmd_o = c8ic_pkg::CMD_LATCH;
      c8ic_pkg::S_DISPATCH: cmd_o = c8ic_pkg::CMD_DISPATCH;
      c8ic_pkg::S_FETCH_LO: cmd_o = c8ic_pkg::CMD_FETCH_LO;
      c8ic_pkg::S_DECODE:   cmd_o = c8ic_pkg::CMD_DECODE;
      c8ic_pkg::S_READ_VX:  cmd_o = c8ic_pkg::CMD_READ_VX;
      c8ic_pkg::S_READ_VY:  cmd_o = c8ic_pkg::CMD_READ_VY;
      c8ic_pkg::S_EXEC:     cmd_o = c8ic_pkg::CMD_EXEC;
      c8ic_pkg::S_SPR_RD:   cmd_o = c8ic_pkg::CMD_SPR_RD;
      c8ic_pkg::S_SPR_WR:   cmd_o = c8ic_pkg::CMD_SPR_WR;
      c8ic_pkg::S_BCD:      cmd_o = c8ic_pkg::CMD_BCD;
      c8ic_pkg::S_STORE:    cmd_o = c8ic_pkg::CMD_STORE;
      c8ic_pkg::S_LOAD_RD:  cmd_o = c8ic_pkg::CMD_LOAD_RD;
      c8ic_pkg::S_LOAD_WR:  cmd_o = c8ic_pkg::CMD_LOAD_WR;
      c8ic_pkg::S_FLAG:     cmd_o = c8ic_pkg::CMD_FLAG;
      c8ic_pkg::S_DONE:     if (out_free) cmd_o = c8ic_pkg::CMD_EMIT;
      default:              cmd_o = c8ic_pkg::CMD_NONE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o == c8ic_pkg::CMD_EMIT) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= c8ic_pkg::S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != c8ic_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[sv/c8ic_dp.sv]
`timescale 1ns / 1ps

module c8ic_dp #(
  parameter int MEM_BYTES     = c8ic_pkg::MemBytesDef,
  parameter int STACK_DEPTH   = c8ic_pkg::StackDepthDef,
  parameter int PROGRAM_START = c8ic_pkg::ProgramStartDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  c8ic_pkg::in_req_t    in_req_i,
  input  c8ic_pkg::dp_cmd_e    cmd_i,
  output c8ic_pkg::dp_status_t sts_o,
  output c8ic_pkg::out_rsp_t   out_rsp_o
);

  localparam int AW  = $clog2(MEM_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int YW  = $clog2(c8ic_pkg::ScreenHeight);
  localparam int XW  = $clog2(c8ic_pkg::ScreenWidth);
  localparam int SW  = c8ic_pkg::ScreenWidth;
  localparam logic [11:0] PcReset = 12'(PROGRAM_START);

  // address modulo memory size, input below 8 times the size
  function automatic logic [AW-1:0] mem_wrap(input logic [12:0] v);
    logic [14:0] t;
    t = {2'b00, v};
    for (int k = 2; k >= 0; k--) begin
      if (t >= 15'(MEM_BYTES << k)) t = t - 15'(MEM_BYTES << k);
    end
    return t[AW-1:0];
  endfunction

  c8ic_pkg::in_req_t  req_q;
  c8ic_pkg::out_rsp_t rsp_q;
  c8ic_pkg::status_e  status_q;
  c8ic_pkg::op_kind_e kind;

  logic [11:0]    pc_q, i_q;
  logic [7:0]     regs_q [16];
  logic [11:0]    stack_q [STACK_DEPTH];
  logic [SPW-1:0] sp_q;
  logic [7:0]     dt_q, st_q;
  logic [SW-1:0]  frame_q [c8ic_pkg::ScreenHeight];
  logic [AW-1:0]  clr_q;
  logic [15:0]    op_q;
  logic [7:0]     hi_q, vx_q, vy_q;
  logic [3:0]     cnt_q;
  logic           coll_q, flag_q;
  logic [31:0]    row_q;

  logic [3:0]  x, y, n, rd_addr, rf_wa, last;
  logic [7:0]  nn, rd_data, rf_wd, alu_res, rdata, wdata, digit, rem, ones;
  logic [11:0] nnn, pc_plus;
  logic        alu_flag, alu_ok, skip, key, hit, rf_we, we, sp_full, sp_empty;
  logic [AW-1:0] raddr, waddr, mem_idx;
  logic [1:0]  hund;
  logic [3:0]  tens;
  logic [YW-1:0] row_y, fr_idx;
  logic [SW-1:0] mask, fr_rd;
  logic [2*SW-1:0] rot;
  logic [SIW-1:0]  sp_dec;

  assign x   = op_q[11:8];
  assign y   = op_q[7:4];
  assign n   = op_q[3:0];
  assign nn  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign pc_plus  = pc_q + 12'd2;
  assign sp_full  = (sp_q >= SPW'(STACK_DEPTH));
  assign sp_empty = (sp_q == '0);
  assign sp_dec   = SIW'(sp_q - SPW'(1));
  assign mem_idx  = mem_wrap({1'b0, i_q} + 13'(cnt_q));

  // register file read port
  always_comb begin
    unique case (cmd_i)
      c8ic_pkg::CMD_READ_VX: rd_addr = x;
      c8ic_pkg::CMD_READ_VY: rd_addr = y;
      default:               rd_addr = cnt_q;
    endcase
  end
  assign rd_data = regs_q[rd_addr];

  always_comb begin
    alu_res  = vx_q;
    alu_flag = 1'b0;
    alu_ok   = 1'b1;
    unique case (n)
      4'h0: alu_res = vy_q;
      4'h1: alu_res = vx_q | vy_q;
      4'h2: alu_res = vx_q & vy_q;
      4'h3: alu_res = vx_q ^ vy_q;
      4'h4: {alu_flag, alu_res} = {1'b0, vx_q} + {1'b0, vy_q};
      4'h5: begin
        alu_res  = vx_q - vy_q;
        alu_flag = (vx_q >= vy_q);
      end
      4'h6: begin
        alu_res  = {1'b0, vx_q[7:1]};
        alu_flag = vx_q[0];
      end
      4'h7: begin
        alu_res  = vy_q - vx_q;
        alu_flag = (vy_q >= vx_q);
      end
      4'hE: begin
        alu_res  = {vx_q[6:0], 1'b0};
        alu_flag = vx_q[7];
      end
      default: alu_ok = 1'b0;
    endcase
  end

  always_comb begin
    kind = c8ic_pkg::KIND_SIMPLE;
    unique case (op_q[15:12])
      4'hD: kind = (n == 4'h0) ? c8ic_pkg::KIND_FLAG : c8ic_pkg::KIND_SPRITE;
      4'h8: begin
        if (n == 4'h4 || n == 4'h5 || n == 4'h6 || n == 4'h7 || n == 4'hE) begin
          kind = c8ic_pkg::KIND_FLAG;
        end
      end
      4'hF: begin
        if (nn == 8'h33) kind = c8ic_pkg::KIND_BCD;
        else if (nn == 8'h55) kind = c8ic_pkg::KIND_STORE;
        else if (nn == 8'h65) kind = c8ic_pkg::KIND_LOAD;
      end
      default: kind = c8ic_pkg::KIND_SIMPLE;
    endcase
  end

  always_comb begin
    unique case (kind)
      c8ic_pkg::KIND_SPRITE: last = n - 4'd1;
      c8ic_pkg::KIND_BCD:    last = 4'd2;
      default:               last = x;
    endcase
  end

  assign sts_o.clr_last  = (clr_q == AW'(MEM_BYTES - 1));
  assign sts_o.func      = c8ic_pkg::func_e'(req_q.func);
  assign sts_o.kind      = kind;
  assign sts_o.loop_last = (cnt_q == last);

  assign key = req_q.keys[vx_q[3:0]];
  always_comb begin
    unique case (op_q[15:12])
      4'h3:    skip = (vx_q == nn);
      4'h4:    skip = (vx_q != nn);
      4'h5:    skip = (vx_q == vy_q);
      4'h9:    skip = (vx_q != vy_q);
      4'hE:    skip = (nn == 8'h9E) ? key : ((nn == 8'hA1) && !key);
      default: skip = 1'b0;
    endcase
  end

  // decimal digits by compare and subtract
  always_comb begin
    if (vx_q >= 8'd200) begin
      hund = 2'd2;
      rem  = vx_q - 8'd200;
    end else if (vx_q >= 8'd100) begin
      hund = 2'd1;
      rem  = vx_q - 8'd100;
    end else begin
      hund = 2'd0;
      rem  = vx_q;
    end
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem >= 8'(k * 10)) tens = 4'(k);
    end
    ones = rem - 8'({4'd0, tens} * 8'd10);
    unique case (cnt_q)
      4'd0:    digit = {6'd0, hund};
      4'd1:    digit = {4'd0, tens};
      default: digit = ones;
    endcase
  end

  // sprite row placed at column vx with wrap
  assign row_y  = vy_q[YW-1:0] + YW'(cnt_q);
  assign fr_idx = (cmd_i == c8ic_pkg::CMD_DISPATCH) ? req_q.display_word[5:1] : row_y;
  assign fr_rd  = frame_q[fr_idx];
  assign rot    = {rdata, {(SW - 8){1'b0}}, rdata, {(SW - 8){1'b0}}} >> vx_q[XW-1:0];
  assign mask   = rot[SW-1:0];
  assign hit    = |(fr_rd & mask);

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    raddr = mem_wrap({1'b0, pc_q});
    unique case (cmd_i)
      c8ic_pkg::CMD_CLEAR: begin
        we    = 1'b1;
        wdata = (clr_q < AW'(c8ic_pkg::FontBytes)) ? c8ic_pkg::FontRom[clr_q[6:0]] : 8'h00;
      end
      c8ic_pkg::CMD_DISPATCH: begin
        we    = (req_q.func == c8ic_pkg::FUNC_LOAD);
        waddr = mem_wrap({1'b0, req_q.mem_addr});
        wdata = req_q.mem_data;
      end
      c8ic_pkg::CMD_FETCH_LO: raddr = mem_wrap({1'b0, pc_q} + 13'd1);
      c8ic_pkg::CMD_SPR_RD, c8ic_pkg::CMD_LOAD_RD: raddr = mem_idx;
      c8ic_pkg::CMD_BCD: begin
        we    = 1'b1;
        waddr = mem_idx;
        wdata = digit;
      end
      c8ic_pkg::CMD_STORE: begin
        we    = 1'b1;
        waddr = mem_idx;
        wdata = rd_data;
      end
      default: we = 1'b0;
    endcase
  end

  c8ic_ram #(
    .WIDTH(8),
    .DEPTH(MEM_BYTES)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // register file write port
  always_comb begin
    rf_we = 1'b0;
    rf_wa = x;
    rf_wd = alu_res;
    unique case (cmd_i)
      c8ic_pkg::CMD_EXEC: begin
        unique case (op_q[15:12])
          4'h6: begin
            rf_we = 1'b1;
            rf_wd = nn;
          end
          4'h7: begin
            rf_we = 1'b1;
            rf_wd = vx_q + nn;
          end
          4'h8: rf_we = alu_ok;
          4'hC: begin
            rf_we = 1'b1;
            rf_wd = req_q.random_byte & nn;
          end
          4'hF: begin
            rf_we = (nn == 8'h07);
            rf_wd = dt_q;
          end
          default: rf_we = 1'b0;
        endcase
      end
      c8ic_pkg::CMD_LOAD_WR: begin
        rf_we = 1'b1;
        rf_wa = cnt_q;
        rf_wd = rdata;
      end
      c8ic_pkg::CMD_FLAG: begin
        rf_we = 1'b1;
        rf_wa = 4'hF;
        rf_wd = {7'd0, flag_q};
      end
      default: rf_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q    <= PcReset;
      i_q     <= '0;
      regs_q  <= '{default: '0};
      sp_q    <= '0;
      dt_q    <= '0;
      st_q    <= '0;
      frame_q <= '{default: '0};
      clr_q   <= '0;
    end else begin
      if (rf_we) regs_q[rf_wa] <= rf_wd;
      unique case (cmd_i)
        c8ic_pkg::CMD_CLEAR: clr_q <= clr_q + AW'(1);
        c8ic_pkg::CMD_DISPATCH: begin
          if (req_q.func == c8ic_pkg::FUNC_TICK) begin
            if (dt_q != '0) dt_q <= dt_q - 8'd1;
            if (st_q != '0) st_q <= st_q - 8'd1;
          end
        end
        c8ic_pkg::CMD_DECODE: pc_q <= pc_plus;
        c8ic_pkg::CMD_EXEC: begin
          unique case (op_q[15:12])
            4'h0: begin
              if (op_q == 16'h00E0) begin
                frame_q <= '{default: '0};
              end else if (op_q == 16'h00EE && !sp_empty) begin
                sp_q <= sp_q - SPW'(1);
                pc_q <= stack_q[sp_dec];
              end
            end
            4'h1: pc_q <= nnn;
            4'h2: begin
              if (!sp_full) begin
                sp_q <= sp_q + SPW'(1);
                pc_q <= nnn;
              end
            end
            4'h3, 4'h4, 4'h5, 4'h9, 4'hE: if (skip) pc_q <= pc_plus;
            4'hA: i_q <= nnn;
            4'hB: pc_q <= nnn + {4'd0, regs_q[0]};
            4'hF: begin
              if (nn == 8'h15) dt_q <= vx_q;
              if (nn == 8'h18) st_q <= vx_q;
              if (nn == 8'h1E) i_q <= i_q + {4'd0, vx_q};
              if (nn == 8'h29) i_q <= {8'd0, vx_q[3:0]} * 12'd5;
            end
            default: pc_q <= pc_q;
          endcase
        end
        c8ic_pkg::CMD_SPR_WR: frame_q[row_y] <= fr_rd ^ mask;
        default: clr_q <= clr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == c8ic_pkg::CMD_EXEC && op_q[15:12] == 4'h2 && !sp_full) begin
      stack_q[sp_q[SIW-1:0]] <= pc_q;
    end
    unique case (cmd_i)
      c8ic_pkg::CMD_LATCH: begin
        req_q    <= in_req_i;
        status_q <= c8ic_pkg::ST_OK;
        coll_q   <= 1'b0;
        flag_q   <= 1'b0;
        row_q    <= '0;
        op_q     <= '0;
        cnt_q    <= '0;
      end
      c8ic_pkg::CMD_DISPATCH: begin
        if (req_q.func == c8ic_pkg::FUNC_DISP) begin
          row_q <= req_q.display_word[0] ? fr_rd[31:0] : fr_rd[SW-1:32];
        end
      end
      c8ic_pkg::CMD_FETCH_LO: hi_q <= rdata;
      c8ic_pkg::CMD_DECODE:   op_q <= {hi_q, rdata};
      c8ic_pkg::CMD_READ_VX:  vx_q <= rd_data;
      c8ic_pkg::CMD_READ_VY:  vy_q <= rd_data;
      c8ic_pkg::CMD_EXEC: begin
        flag_q <= (op_q[15:12] == 4'h8) ? alu_flag : 1'b0;
        unique case (op_q[15:12])
          4'h0: if (op_q == 16'h00EE && sp_empty) status_q <= c8ic_pkg::ST_UNDERFLOW;
          4'h2: if (sp_full) status_q <= c8ic_pkg::ST_OVERFLOW;
          4'h8: if (!alu_ok) status_q <= c8ic_pkg::ST_UNKNOWN;
          4'hE: if (nn != 8'h9E && nn != 8'hA1) status_q <= c8ic_pkg::ST_UNKNOWN;
          4'hF: begin
            if (nn != 8'h07 && nn != 8'h15 && nn != 8'h18 && nn != 8'h1E &&
                nn != 8'h29 && nn != 8'h33 && nn != 8'h55 && nn != 8'h65) begin
              status_q <= c8ic_pkg::ST_UNKNOWN;
            end
          end
          default: status_q <= status_q;
        endcase
      end
      c8ic_pkg::CMD_SPR_WR: begin
        coll_q <= coll_q | hit;
        flag_q <= coll_q | hit;
        cnt_q  <= cnt_q + 4'd1;
      end
      c8ic_pkg::CMD_BCD, c8ic_pkg::CMD_STORE, c8ic_pkg::CMD_LOAD_WR: cnt_q <= cnt_q + 4'd1;
      c8ic_pkg::CMD_EMIT: begin
        rsp_q.pc        <= pc_q;
        rsp_q.opcode    <= op_q;
        rsp_q.status    <= status_q;
        rsp_q.collision <= coll_q;
        rsp_q.sound_on  <= (st_q != '0);
        rsp_q.row_data  <= row_q;
      end
      default: cnt_q <= cnt_q;
    endcase
  end

  assign out_rsp_o = rsp_q;

endmodule

[sv/chip8_instruction_core.sv]
`timescale 1ns / 1ps

// chip8_instruction_core: one request in, one response out.
// a request carries func: load a memory byte, execute one instruction,
// tick both timers, or read one 32-pixel word of the frame buffer.
// in_valid_i/in_stall_o take a request when valid is high and stall low;
// out_valid_o/out_stall_i hand over the response the same way.
// one request is worked on at a time; the next one is taken as soon as
// the previous response sits in the output register, even if stalled.
// load, tick and display read pass dispatch and done; an instruction adds
// fetch, decode, reads of VX and VY and execute, then a read and write per
// sprite row and a VF write (DXYN), a BCD step per digit, a store per
// register (FX55), a read and write per register (FX65), or a VF write
// alone. the next request is taken in the cycle after the response is
// loaded. cost is set by the byte memory (one read, one write port) and
// the register file ports, each moving one byte per cycle. after reset
// the memory is swept once, writing the font into the first 80 bytes and
// zero elsewhere; in_stall_o stays high then. a stalled response holds
// and the core waits before finishing the next.

module chip8_instruction_core #(
  parameter int MEM_BYTES     = c8ic_pkg::MemBytesDef,
  parameter int STACK_DEPTH   = c8ic_pkg::StackDepthDef,
  parameter int PROGRAM_START = c8ic_pkg::ProgramStartDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  c8ic_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output c8ic_pkg::out_rsp_t out_rsp_o
);

  c8ic_pkg::dp_cmd_e    cmd;
  c8ic_pkg::dp_status_t sts;

  c8ic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  c8ic_dp #(
    .MEM_BYTES    (MEM_BYTES),
    .STACK_DEPTH  (STACK_DEPTH),
    .PROGRAM_START(PROGRAM_START)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_req_i (in_req_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_rsp_o(out_rsp_o)
  );

endmodule

[sv/c8ic_checker.sv]
`timescale 1ns / 1ps
`include "chip8_instruction_core_macros.svh"

module c8ic_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input c8ic_pkg::out_rsp_t out_rsp_o
);

  logic in_take, rsp_wait, coll_seen, row_seen, rsp_plain;

  assign in_take   = in_valid_i && !in_stall_o;
  assign rsp_wait  = out_valid_o && out_stall_i;
  assign coll_seen = out_valid_o && out_rsp_o.collision;
  assign row_seen  = out_valid_o && (out_rsp_o.row_data != 32'h0);
  assign rsp_plain = (out_rsp_o.opcode == 16'h0) && (out_rsp_o.collision == 1'b0);

  // a taken request keeps the core busy in the cycle after
  `C8IC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_take, in_stall_o)

  `C8IC_ASSERT_NXT(a_rsp_hold, clk_i, rst_ni, rsp_wait, out_valid_o && $stable(out_rsp_o))

  // sprite draws never fail
  `C8IC_ASSERT_IMP(a_coll_ok, clk_i, rst_ni, coll_seen, out_rsp_o.status == c8ic_pkg::ST_OK)

  // pixel data only comes with display reads
  `C8IC_ASSERT_IMP(a_row_only_disp, clk_i, rst_ni, row_seen, rsp_plain)

endmodule

bind chip8_instruction_core c8ic_checker u_c8ic_checker (.*);
